FILE: hw/rtl/tts_pkg.sv
// shared types, constants and segment table for the temperature display converter
package tts_pkg;

  localparam int RAW_W  = 12;
  localparam int MAG_W  = 12;
  localparam int HUND_W = 14;
  localparam int Q_W    = 8;
  localparam int R_W    = 7;
  localparam int DIG_W  = 4;
  localparam int SEG_W  = 8;

  // hund / 100 as (hund * RECIP100) >> SHIFT100, exact for hund <= 12800
  localparam logic [12:0] RECIP100 = 13'd5243;
  localparam int          SHIFT100 = 19;
  // v / 10 as (v * RECIP10) >> SHIFT10, exact for v < 1029
  localparam logic [7:0]  RECIP10  = 8'd205;
  localparam int          SHIFT10  = 11;

  localparam logic [SEG_W-1:0] MINUS_CODE = 8'h40;
  localparam logic [SEG_W-1:0] POINT_BIT  = 8'h80;
  localparam logic [SEG_W-1:0] BLANK_CODE = 8'h00;

  localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  typedef logic [HUND_W-1:0] hund_t;
  typedef logic [DIG_W-1:0]  digit_t;
  typedef logic [SEG_W-1:0]  seg_t;

  typedef struct packed {
    logic                 negative;
    logic [R_W-1:0]       rem100;
    digit_t               q_tens;
    digit_t               q_units;
  } split_t;

  function automatic seg_t seg_of(input digit_t d);
    seg_t s;
    if (d < DIG_W'(10)) begin
      s = SEG_TABLE[d];
    end else begin
      s = BLANK_CODE;
    end
    return s;
  endfunction

endpackage

FILE: hw/rtl/tts_scale.sv
// stage 1: magnitude of the reading scaled to hundredths of a degree
module tts_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [tts_pkg::RAW_W-1:0]     raw_reading,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic                          negative,
  output tts_pkg::hund_t                hund
);
  import tts_pkg::*;

  logic             neg_next;
  logic [MAG_W-1:0] mag;
  logic [15:0]      scaled;

  always_comb begin
    neg_next = raw_reading[RAW_W-1];
    mag      = neg_next ? (MAG_W'(~raw_reading) + MAG_W'(1)) : MAG_W'(raw_reading);
    scaled   = 16'(mag) * 16'd25 + 16'd2;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      negative <= neg_next;
      hund     <= scaled[15:2];
    end
  end

endmodule

FILE: hw/rtl/tts_divide.sv
// stages 2 and 3: split hundredths into a quotient by 100 and its digits
module tts_divide (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic             negative,
  input  tts_pkg::hund_t   hund,
  output logic             dn_valid,
  input  logic             dn_ready,
  output tts_pkg::split_t  split
);
  import tts_pkg::*;

  // stage 2 registers
  logic           a_valid;
  logic           a_negative;
  hund_t          a_hund;
  logic [Q_W-1:0] a_quot;
  logic           a_ready;

  logic [26:0]    quot_prod;

  // stage 3 logic
  logic [HUND_W-1:0] rem_full;
  logic [15:0]       qt_prod;
  digit_t            qt;
  logic [Q_W-1:0]    qu_full;

  assign quot_prod = 27'(hund) * 27'(RECIP100);

  assign a_ready  = !dn_valid || dn_ready;
  assign up_ready = !a_valid || a_ready;

  always_comb begin
    rem_full = a_hund - HUND_W'(a_quot) * HUND_W'(100);
    qt_prod  = 16'(a_quot) * 16'(RECIP10);
    qt       = DIG_W'(qt_prod >> SHIFT10);
    qu_full  = a_quot - Q_W'(qt) * Q_W'(10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        a_valid <= up_valid;
      end
      if (a_ready) begin
        dn_valid <= a_valid;
      end
    end
    if (up_ready && up_valid) begin
      a_negative <= negative;
      a_hund     <= hund;
      a_quot     <= Q_W'(quot_prod >> SHIFT100);
    end
    if (a_ready && a_valid) begin
      split.negative <= a_negative;
      split.rem100   <= rem_full[R_W-1:0];
      split.q_tens   <= qt;
      split.q_units  <= qu_full[DIG_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/tts_encode.sv
// stage 4: last digits and seven-segment codes into the output register
module tts_encode (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  tts_pkg::split_t  split,
  output logic             dn_valid,
  input  logic             dn_ready,
  output tts_pkg::seg_t    sign_code,
  output tts_pkg::seg_t    hundreds_code,
  output tts_pkg::seg_t    tens_code,
  output tts_pkg::seg_t    units_code,
  output tts_pkg::seg_t    tenths_code,
  output tts_pkg::seg_t    hundredths_code
);
  import tts_pkg::*;

  logic [14:0]    rt_prod;
  digit_t         rt;
  logic [R_W-1:0] ru_full;
  logic           over_hundred;
  digit_t         hi_digit;
  digit_t         mid_digit;

  always_comb begin
    rt_prod      = 15'(split.rem100) * 15'(RECIP10);
    rt           = DIG_W'(rt_prod >> SHIFT10);
    ru_full      = split.rem100 - R_W'(rt) * R_W'(10);
    over_hundred = split.q_tens >= DIG_W'(10);
    hi_digit     = over_hundred ? DIG_W'(1) : DIG_W'(0);
    mid_digit    = over_hundred ? (split.q_tens - DIG_W'(10)) : split.q_tens;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      sign_code       <= split.negative ? MINUS_CODE : BLANK_CODE;
      hundreds_code   <= seg_of(hi_digit);
      tens_code       <= seg_of(mid_digit);
      units_code      <= seg_of(split.q_units) | POINT_BIT;
      tenths_code     <= seg_of(rt);
      hundredths_code <= seg_of(ru_full[DIG_W-1:0]);
    end
  end

endmodule

FILE: hw/rtl/temperature_to_segments_unit.sv
// top level: signed temperature reading to six seven-segment codes
//
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall   raw_reading
//  out      from block out_valid / out_stall sign_code, hundreds_code, tens_code,
//                                            units_code, tenths_code, hundredths_code
//
// four register stages: scale, divide by 100, quotient digits, encode
// one item per cycle while out_stall is low; out_valid rises as items reach encode
// rst clears all stage valid bits; payload registers are not reset
// each stage takes a new item while empty or while its successor takes its item,
// so out_stall fills the pipeline without losing or repeating an item
module temperature_to_segments_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [tts_pkg::RAW_W-1:0] raw_reading,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tts_pkg::seg_t             sign_code,
  output tts_pkg::seg_t             hundreds_code,
  output tts_pkg::seg_t             tens_code,
  output tts_pkg::seg_t             units_code,
  output tts_pkg::seg_t             tenths_code,
  output tts_pkg::seg_t             hundredths_code
);
  import tts_pkg::*;

  logic   s1_ready;
  logic   s1_valid;
  logic   s1_negative;
  hund_t  s1_hund;
  logic   s2_ready;
  logic   s2_valid;
  split_t s2_split;
  logic   s3_ready;

  assign in_stall = !s1_ready;

  tts_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (in_valid),
    .up_ready    (s1_ready),
    .raw_reading (raw_reading),
    .dn_valid    (s1_valid),
    .dn_ready    (s2_ready),
    .negative    (s1_negative),
    .hund        (s1_hund)
  );

  tts_divide u_divide (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .negative (s1_negative),
    .hund     (s1_hund),
    .dn_valid (s2_valid),
    .dn_ready (s3_ready),
    .split    (s2_split)
  );

  tts_encode u_encode (
    .clk             (clk),
    .rst             (rst),
    .up_valid        (s2_valid),
    .up_ready        (s3_ready),
    .split           (s2_split),
    .dn_valid        (out_valid),
    .dn_ready        (!out_stall),
    .sign_code       (sign_code),
    .hundreds_code   (hundreds_code),
    .tens_code       (tens_code),
    .units_code      (units_code),
    .tenths_code     (tenths_code),
    .hundredths_code (hundredths_code)
  );

  a_sign_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sign_code == MINUS_CODE || sign_code == BLANK_CODE))
    else $error("sign code is neither minus nor blank");

  a_hundreds_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hundreds_code == SEG_TABLE[0] || hundreds_code == SEG_TABLE[1]))
    else $error("hundreds digit above one");

  a_max_reading: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hundreds_code == SEG_TABLE[1] && tens_code == SEG_TABLE[2]
     && units_code == (SEG_TABLE[8] | POINT_BIT)) |->
      (tenths_code == SEG_TABLE[0] && hundredths_code == SEG_TABLE[0]
       && sign_code == MINUS_CODE))
    else $error("magnitude above 128.00 degrees");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(sign_code) && $stable(hundreds_code) && $stable(tens_code)
       && $stable(units_code) && $stable(tenths_code) && $stable(hundredths_code)))
    else $error("stalled item changed or dropped");

endmodule
